### design/saffron_star_lagged_levels_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SAFFRON_STAR_LAGGED_LEVELS_ASSERT_SVH
`define SAFFRON_STAR_LAGGED_LEVELS_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SSLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SSLL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ssll_pkg.sv
package ssll_pkg;

  localparam int MAX_TESTS = 1024;
  localparam int AW        = $clog2(MAX_TESTS);
  localparam int TS_W      = $clog2(MAX_TESTS + 1);
  localparam int FRAC_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CW        = ((TS_W > IDX_W) ? TS_W : IDX_W) + 2;
  localparam int ACC_W     = FRAC_W + TS_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_W0     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd2;

  localparam logic [FRAC_W-1:0] W0_RST     = 32'd53687091;
  localparam logic [FRAC_W-1:0] LAMBDA_RST = 32'd2147483648;
  localparam logic [FRAC_W-1:0] ALPHA_RST  = 32'd214748365;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  // history entry k: outcome flags of test k and lagged count of test k+1
  typedef struct packed {
    logic            rej;
    logic            cand;
    logic [TS_W-1:0] cnt;
  } hist_t;

  localparam int HIST_W = $bits(hist_t);

  // tag that travels with a gamma read into the accumulator
  typedef struct packed {
    logic            valid;
    logic            base;
    logic            first;
    logic [TS_W-1:0] reps;
  } term_tag_t;

endpackage

### design/ssll_ram.sv
module ssll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ssll_acc.sv
module ssll_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_i,
  input  logic [ssll_pkg::FRAC_W-1:0]         w0_i,
  input  logic [ssll_pkg::FRAC_W-1:0]         a_i,
  input  ssll_pkg::term_tag_t                 tag_i,
  input  logic [ssll_pkg::FRAC_W-1:0]         g_i,
  output logic                                busy_o,
  output logic signed [ssll_pkg::ACC_W-1:0]   acc_o
);

  localparam int FW = ssll_pkg::FRAC_W;
  localparam int PW = ssll_pkg::FRAC_W + ssll_pkg::TS_W;

  ssll_pkg::term_tag_t             s1_tag_q;
  logic [FW-1:0]                   pa_q, pw_q;
  logic [2*FW-1:0]                 pa_full, pw_full;
  logic [PW-1:0]                   rp;
  logic signed [ssll_pkg::ACC_W-1:0] t_d, t_q, pw_ext, acc_q;
  logic                            s2_v_q;

  assign pa_full = (2*FW)'(a_i) * (2*FW)'(g_i);
  assign pw_full = (2*FW)'(w0_i) * (2*FW)'(g_i);

  // term = reps*trunc(a*g) + trunc(w0*g) for the base, - trunc(w0*g) for the first run
  always_comb begin
    rp     = PW'(s1_tag_q.reps) * PW'(pa_q);
    pw_ext = $signed(ssll_pkg::ACC_W'(pw_q));
    t_d    = $signed(ssll_pkg::ACC_W'(rp));
    if (s1_tag_q.base) begin
      t_d = t_d + pw_ext;
    end
    if (s1_tag_q.first) begin
      t_d = t_d - pw_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_v_q   <= 1'b0;
      acc_q    <= '0;
    end else begin
      s1_tag_q <= tag_i;
      s2_v_q   <= s1_tag_q.valid;
      if (clear_i) begin
        acc_q <= '0;
      end else if (s2_v_q) begin
        acc_q <= acc_q + t_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q <= pa_full[2*FW-1:FW];
    pw_q <= pw_full[2*FW-1:FW];
    t_q  <= t_d;
  end

  assign busy_o = s1_tag_q.valid | s2_v_q;
  assign acc_o  = acc_q;

endmodule

### design/saffron_star_lagged_levels.sv
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+--------------------------------------
// in       | input     | in_valid_i / in_ready_o      | req_type, gamma_index, gamma_value,
//          |           |                              | p_value, lag
// out      | output    | out_valid_o / out_ready_i    | test_index, test_level, rejected, error
// cfg      | input     | cfg_we_i (no back-pressure)  | cfg_index_i, cfg_data_i
//
// A load transaction and a refused test go straight from idle to the result state.
// Each test scans the single-port history memory
// twice (counts, then rejection times), one entry per cycle.
// Reset is asynchronous; history is tracked by the test count, no clearing pass.
// The input is taken only when the engine is idle; a finished result waits in
// the output register, so the next transaction may be taken before it drains.
module saffron_star_lagged_levels (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input transactions
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 req_type_i,
  input  logic [ssll_pkg::IDX_W-1:0]           gamma_index_i,
  input  logic [ssll_pkg::FRAC_W-1:0]          gamma_value_i,
  input  logic [ssll_pkg::FRAC_W-1:0]          p_value_i,
  input  logic [ssll_pkg::IDX_W-1:0]           lag_i,
  // result transactions
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ssll_pkg::IDX_W-1:0]           test_index_o,
  output logic [ssll_pkg::FRAC_W-1:0]          test_level_o,
  output logic                                 rejected_o,
  output logic                                 error_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [ssll_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ssll_pkg::FRAC_W-1:0]          cfg_data_i
);

  localparam int AW   = ssll_pkg::AW;
  localparam int TS_W = ssll_pkg::TS_W;
  localparam int CW   = ssll_pkg::CW;
  localparam int FW   = ssll_pkg::FRAC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,   // count rejections and candidates inside the lag window
    ST_WR_CNT,   // store the lagged count, fetch the base gamma
    ST_SCAN_B,   // walk the counts, one gamma fetch per new running max
    ST_DRAIN,    // let the accumulator pipeline empty
    ST_CLAMP,
    ST_WB,       // write the outcome flags back
    ST_RESULT
  } state_e;

  state_e state_q;

  // configuration
  logic [FW-1:0] w0_q, lam_q, alpha_q, a_q;
  logic [FW:0]   one_minus_lam;
  logic [2*FW:0] amul;

  // test context
  logic [TS_W-1:0]             ts_q;
  logic [FW-1:0]               p_q;
  logic [ssll_pkg::IDX_W-1:0]  lag_q;
  logic [TS_W-1:0]             k_q, rk_q;
  logic                        rv_q;
  logic [TS_W-1:0]             cond_q, csum_q, cpr_q, mx_q;
  logic                        lrej_q, lcand_q;
  logic [FW-1:0]               lvl_q;

  // pending result
  logic [ssll_pkg::IDX_W-1:0]  res_idx_q;
  logic [FW-1:0]               res_lvl_q;
  logic                        res_rej_q, res_err_q;

  // output register
  logic                        out_valid_q;
  logic [ssll_pkg::IDX_W-1:0]  out_idx_q;
  logic [FW-1:0]               out_lvl_q;
  logic                        out_rej_q, out_err_q;

  // memories
  logic                        g_we;
  logic [AW-1:0]               g_addr;
  logic [FW-1:0]               g_rdata;
  logic                        h_we;
  logic [AW-1:0]               h_addr;
  ssll_pkg::hist_t             h_wdata, h_rd;
  logic [ssll_pkg::HIST_W-1:0] h_rdata;

  // accumulator link
  ssll_pkg::term_tag_t         tag_d, tag_q;
  logic                        acc_busy;
  logic signed [ssll_pkg::ACC_W-1:0] acc;

  // datapath helpers
  logic                        in_acc, issue, scanning;
  logic                        inlim_r, inlim_nx, new_run;
  logic [TS_W-1:0]             cpr_n, c_val, run_addr;
  logic                        rej_now, cand_now;
  logic [FW-1:0]               lvl_clamped;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign scanning   = (state_q == ST_SCAN_A) || (state_q == ST_SCAN_B);
  assign issue      = scanning && (k_q < ts_q);
  assign h_rd       = ssll_pkg::hist_t'(h_rdata);

  // a = trunc((1 - lambda) * alpha), registered after the multiply
  assign one_minus_lam = {1'b1, {FW{1'b0}}} - {1'b0, lam_q};
  assign amul          = (2*FW+1)'(one_minus_lam) * (2*FW+1)'(alpha_q);

  // returning entry rk_q lies inside the window when rk + lag < i
  assign inlim_r  = (CW'(rk_q) + CW'(lag_q)) < CW'(ts_q);
  assign inlim_nx = (CW'(rk_q) + CW'(lag_q) + CW'(1)) < CW'(ts_q);
  assign cpr_n    = cpr_q + TS_W'(h_rd.cand & inlim_r);
  // candidates strictly after the rejection time and inside the window
  assign c_val    = inlim_nx ? (csum_q - cpr_n) : '0;
  assign new_run  = (state_q == ST_SCAN_B) && rv_q && (h_rd.cnt > mx_q);
  assign run_addr = ts_q - rk_q - c_val - TS_W'(1);

  assign rej_now  = (p_q <= lvl_q);
  assign cand_now = (p_q <= lam_q);

  always_comb begin
    if (acc < 0) begin
      lvl_clamped = '0;
    end else if (acc > $signed(ssll_pkg::ACC_W'(lam_q))) begin
      lvl_clamped = lam_q;
    end else begin
      lvl_clamped = acc[FW-1:0];
    end
  end

  // memory port control
  always_comb begin
    g_we    = 1'b0;
    g_addr  = '0;
    h_we    = 1'b0;
    h_addr  = AW'(k_q);
    h_wdata = '0;
    tag_d   = '0;
    case (state_q)
      ST_IDLE: begin
        g_addr = AW'(gamma_index_i);
        g_we   = in_acc && (req_type_i == ssll_pkg::REQ_LOAD) &&
                 (32'(gamma_index_i) < 32'(ssll_pkg::MAX_TESTS));
      end
      ST_WR_CNT: begin
        g_addr     = AW'(ts_q - csum_q);
        tag_d      = '{valid: 1'b1, base: 1'b1, first: 1'b0, reps: '0};
        h_we       = (ts_q != '0);
        h_addr     = AW'(ts_q - TS_W'(1));
        h_wdata    = '{rej: lrej_q, cand: lcand_q, cnt: cond_q};
      end
      ST_SCAN_B: begin
        g_addr = AW'(run_addr);
        if (new_run) begin
          tag_d = '{valid: 1'b1, base: 1'b0, first: (mx_q == '0), reps: h_rd.cnt - mx_q};
        end
      end
      ST_WB: begin
        h_we    = 1'b1;
        h_addr  = AW'(ts_q);
        h_wdata = '{rej: rej_now, cand: cand_now, cnt: '0};
      end
      default: begin
      end
    endcase
  end

  ssll_ram #(
    .WIDTH (FW),
    .DEPTH (ssll_pkg::MAX_TESTS)
  ) u_gamma_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .addr_i  (g_addr),
    .wdata_i (gamma_value_i),
    .rdata_o (g_rdata)
  );

  ssll_ram #(
    .WIDTH (ssll_pkg::HIST_W),
    .DEPTH (ssll_pkg::MAX_TESTS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .addr_i  (h_addr),
    .wdata_i (h_wdata),
    .rdata_o (h_rdata)
  );

  ssll_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (state_q == ST_WR_CNT),
    .w0_i    (w0_q),
    .a_i     (a_q),
    .tag_i   (tag_q),
    .g_i     (g_rdata),
    .busy_o  (acc_busy),
    .acc_o   (acc)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q    <= ssll_pkg::W0_RST;
      lam_q   <= ssll_pkg::LAMBDA_RST;
      alpha_q <= ssll_pkg::ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ssll_pkg::CFG_W0:     w0_q    <= cfg_data_i;
        ssll_pkg::CFG_LAMBDA: lam_q   <= cfg_data_i;
        ssll_pkg::CFG_ALPHA:  alpha_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= amul[2*FW-1:FW];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ts_q        <= '0;
      k_q         <= '0;
      rk_q        <= '0;
      rv_q        <= 1'b0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q <= tag_d;
      // a result leaving while the next one is loaded keeps valid high
      if (out_valid_q && out_ready_i && (state_q != ST_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      if (scanning) begin
        rv_q <= issue;
        rk_q <= k_q;
        if (issue) begin
          k_q <= k_q + TS_W'(1);
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_lvl_q <= '0;
            res_rej_q <= 1'b0;
            if (req_type_i == ssll_pkg::REQ_LOAD) begin
              res_idx_q <= ssll_pkg::IDX_W'(ts_q);
              res_err_q <= 1'b0;
              state_q   <= ST_RESULT;
            end else if (ts_q == TS_W'(ssll_pkg::MAX_TESTS)) begin
              res_idx_q <= '0;
              res_err_q <= 1'b1;
              state_q   <= ST_RESULT;
            end else begin
              k_q     <= '0;
              rv_q    <= 1'b0;
              cond_q  <= '0;
              csum_q  <= '0;
              state_q <= ST_SCAN_A;
            end
          end
        end
        ST_SCAN_A: begin
          if (rv_q) begin
            cond_q  <= cond_q + TS_W'(h_rd.rej & inlim_r);
            csum_q  <= csum_q + TS_W'(h_rd.cand & inlim_r);
            lrej_q  <= h_rd.rej;
            lcand_q <= h_rd.cand;
          end
          if (!issue && !rv_q) begin
            state_q <= ST_WR_CNT;
          end
        end
        ST_WR_CNT: begin
          k_q     <= '0;
          rv_q    <= 1'b0;
          cpr_q   <= '0;
          mx_q    <= '0;
          state_q <= ST_SCAN_B;
        end
        ST_SCAN_B: begin
          if (rv_q) begin
            cpr_q <= cpr_n;
          end
          if (new_run) begin
            mx_q <= h_rd.cnt;
          end
          if (!issue && !rv_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!tag_q.valid && !acc_busy) begin
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          lvl_q   <= lvl_clamped;
          state_q <= ST_WB;
        end
        ST_WB: begin
          ts_q      <= ts_q + TS_W'(1);
          res_idx_q <= ssll_pkg::IDX_W'(ts_q);
          res_lvl_q <= lvl_q;
          res_rej_q <= rej_now;
          res_err_q <= 1'b0;
          state_q   <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= res_idx_q;
            out_lvl_q   <= res_lvl_q;
            out_rej_q   <= res_rej_q;
            out_err_q   <= res_err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q   <= p_value_i;
      lag_q <= lag_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign test_index_o = out_idx_q;
  assign test_level_o = out_lvl_q;
  assign rejected_o   = out_rej_q;
  assign error_o      = out_err_q;

endmodule

### design/ssll_checker.sv
`include "saffron_star_lagged_levels_assert.svh"

module ssll_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [ssll_pkg::IDX_W-1:0]     test_index_o,
  input logic [ssll_pkg::FRAC_W-1:0]    test_level_o,
  input logic                           rejected_o,
  input logic                           error_o
);

  // result holds until taken
  `SSLL_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // a refused test reports nothing else
  `SSLL_ASSERT_IMP(a_err_clean, out_valid_o && error_o,
                   test_level_o == '0 && !rejected_o && test_index_o == '0,
                   "error result carries data")

  // a rejection is never an error
  `SSLL_ASSERT_IMP(a_rej_no_err, out_valid_o && rejected_o, !error_o, "rejected with error")

  // the engine is not ready again in the cycle after taking a transaction
  `SSLL_ASSERT_NXT(a_busy_after_acc, in_valid_i && in_ready_o, !in_ready_o,
                   "input taken on back-to-back cycles")

endmodule

bind saffron_star_lagged_levels ssll_checker u_ssll_checker (.*);

### tb/tb_saffron_star_lagged_levels.sv
`timescale 1ns / 1ps

module tb_saffron_star_lagged_levels;

  localparam int FRAC_W    = ssll_pkg::FRAC_W;
  localparam int IDX_W     = ssll_pkg::IDX_W;
  localparam int CFG_IDX_W = ssll_pkg::CFG_IDX_W;
  localparam int MAX_TESTS = ssll_pkg::MAX_TESTS;

  // Register index past the three real registers; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;
  // gamma entries written up front; tests stay below this count
  localparam int GAMMA_FILL = 128;

  typedef struct {
    logic              req;
    logic [IDX_W-1:0]  gidx;
    logic [FRAC_W-1:0] gval;
    logic [FRAC_W-1:0] pval;
    logic [IDX_W-1:0]  lag;
  } fdr_req_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] level;
    logic              rej;
    logic              err;
  } fdr_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              req_type_i = ssll_pkg::REQ_LOAD;
  logic [IDX_W-1:0]  gamma_index_i = '0;
  logic [FRAC_W-1:0] gamma_value_i = '0;
  logic [FRAC_W-1:0] p_value_i = '0;
  logic [IDX_W-1:0]  lag_i = '0;

  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [IDX_W-1:0]  test_index_o;
  logic [FRAC_W-1:0] test_level_o;
  logic              rejected_o;
  logic              error_o;

  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [FRAC_W-1:0]    cfg_data_i = '0;

  saffron_star_lagged_levels dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state of the FDR procedure
  // ---------------------------------------------------------------------------
  logic [FRAC_W-1:0] sh_w0 = ssll_pkg::W0_RST;
  logic [FRAC_W-1:0] sh_lambda = ssll_pkg::LAMBDA_RST;
  logic [FRAC_W-1:0] sh_alpha = ssll_pkg::ALPHA_RST;

  logic [FRAC_W-1:0] sh_gamma [MAX_TESTS];
  logic              sh_rej   [MAX_TESTS];
  logic              sh_cand  [MAX_TESTS];
  int                sh_cnt   [MAX_TESTS];
  int                sh_tests = 0;

  fdr_req_t     pending_reqs[$];
  fdr_verdict_t expected_verdicts[$];
  int           mismatches = 0;
  int           tests_queued = 0;

  initial begin
    for (int k = 0; k < MAX_TESTS; k++) begin
      sh_rej[k] = 1'b0;
      sh_cand[k] = 1'b0;
      sh_cnt[k] = 0;
      sh_gamma[k] = '0;
    end
  end

  function automatic longint qmul(logic [FRAC_W-1:0] x, logic [FRAC_W-1:0] y);
    logic [63:0] prod;
    prod = 64'(x) * 64'(y);
    return longint'(prod >> 32);
  endfunction

  function automatic logic [FRAC_W-1:0] gamma_at(int idx);
    if (idx < 0 || idx >= MAX_TESTS) return '0;
    return sh_gamma[idx];
  endfunction

  // Level for test i; also records the lagged rejection count of test i.
  function automatic logic [FRAC_W-1:0] saffron_level(int i, int lag);
    longint acc;
    int lim, cond, csum, kmax, r, cp;
    logic [95:0] aprod;
    logic [FRAC_W-1:0] a, g;
    if (i == 0) begin
      acc = qmul(sh_gamma[0], sh_w0);
    end else begin
      lim = i - lag;
      cond = 0;
      csum = 0;
      for (int j = 0; j < i; j++) begin
        if (j < lim) begin
          cond += sh_rej[j];
          csum += sh_cand[j];
        end
      end
      sh_cnt[i-1] = cond;
      kmax = 0;
      for (int j = 0; j < i; j++) if (sh_cnt[j] > kmax) kmax = sh_cnt[j];
      aprod = ((96'(1) << 32) - 96'(sh_lambda)) * 96'(sh_alpha);
      a = aprod[63:32];
      acc = qmul(sh_w0, gamma_at(i - csum));
      r = 0;
      for (int y = 0; y < kmax; y++) begin
        // rejection times grow with y, so the scan resumes where it stopped
        while (r < i && !(sh_cnt[r] > y)) r++;
        cp = 0;
        for (int k = r + 1; k < i; k++) if (k < lim && sh_cand[k]) cp++;
        g = gamma_at(i - r - cp - 1);
        acc += qmul(a, g);
        if (y == 0) acc -= qmul(sh_w0, g);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(sh_lambda)) acc = longint'(sh_lambda);
    return acc[FRAC_W-1:0];
  endfunction

  function automatic fdr_verdict_t predict_verdict(fdr_req_t rq);
    fdr_verdict_t v;
    v = '{idx: '0, level: '0, rej: 1'b0, err: 1'b0};
    if (rq.req == ssll_pkg::REQ_LOAD) begin
      sh_gamma[rq.gidx] = rq.gval;
      v.idx = sh_tests[IDX_W-1:0];
    end else if (sh_tests >= MAX_TESTS) begin
      v.err = 1'b1;
    end else begin
      v.idx = sh_tests[IDX_W-1:0];
      v.level = saffron_level(sh_tests, int'(rq.lag));
      v.rej = rq.pval <= v.level;
      sh_rej[sh_tests] = v.rej;
      sh_cand[sh_tests] = rq.pval <= sh_lambda;
      sh_tests++;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued transactions, random gap before each one
  // ---------------------------------------------------------------------------
  int       in_gap = 0;
  fdr_req_t cur_req;

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int g;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else if (in_valid_i && in_ready_o) begin
      expected_verdicts.insert(expected_verdicts.size(), predict_verdict(cur_req));
      g = draw_gap();
      if (g == 0 && pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_type_i <= cur_req.req;
        gamma_index_i <= cur_req.gidx;
        gamma_value_i <= cur_req.gval;
        p_value_i <= cur_req.pval;
        lag_i <= cur_req.lag;
      end else begin
        in_valid_i <= 1'b0;
        in_gap <= g;
      end
    end else if (!in_valid_i) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_type_i <= cur_req.req;
        gamma_index_i <= cur_req.gidx;
        gamma_value_i <= cur_req.gval;
        p_value_i <= cur_req.pval;
        lag_i <= cur_req.lag;
        in_valid_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall before each result, compares against the oldest
  // ---------------------------------------------------------------------------
  int out_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    fdr_verdict_t ev;
    int s;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result transaction: test_index %0d", test_index_o);
        mismatches++;
      end else begin
        ev = expected_verdicts.pop_front();
        if (test_index_o !== ev.idx) begin
          $error("test_index: expected %0d, got %0d", ev.idx, test_index_o);
          mismatches++;
        end
        if (test_level_o !== ev.level) begin
          $error("test_level: expected %08h, got %08h", ev.level, test_level_o);
          mismatches++;
        end
        if (rejected_o !== ev.rej) begin
          $error("rejected: expected %0b, got %0b", ev.rej, rejected_o);
          mismatches++;
        end
        if (error_o !== ev.err) begin
          $error("error: expected %0b, got %0b", ev.err, error_o);
          mismatches++;
        end
      end
      s = draw_gap();
      if (s > 0) begin
        out_ready_i <= 1'b0;
        out_stall <= s;
      end
    end else if (!out_ready_i) begin
      if (out_stall > 1) out_stall <= out_stall - 1;
      else begin
        out_stall <= 0;
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** saffron_star_lagged_levels: FAILED **");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_load(int idx, logic [FRAC_W-1:0] val);
    fdr_req_t rq;
    rq = '{req: ssll_pkg::REQ_LOAD, gidx: IDX_W'(idx), gval: val,
           pval: $urandom(), lag: IDX_W'($urandom())};
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  task automatic queue_test(logic [FRAC_W-1:0] p, int lag);
    fdr_req_t rq;
    rq = '{req: ssll_pkg::REQ_TEST, gidx: IDX_W'($urandom()), gval: $urandom(),
           pval: p, lag: IDX_W'(lag)};
    pending_reqs.insert(pending_reqs.size(), rq);
    tests_queued++;
  endtask

  // gamma values spread over many magnitudes, extremes now and then
  function automatic logic [FRAC_W-1:0] rand_gamma();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FRAC_MAX;
      default: return $urandom() >> $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] rand_pval();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FRAC_MAX;
      2, 3: return $urandom();
      4: return sh_lambda;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic int rand_lag();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1023;
      2, 3: return $urandom_range(0, 1023);
      default: return $urandom_range(0, 4);
    endcase
  endfunction

  // tests only while they stay inside the written gamma entries
  task automatic queue_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0 || tests_queued >= GAMMA_FILL - 4)
        queue_load($urandom_range(0, MAX_TESTS - 1), rand_gamma());
      else queue_test(rand_pval(), rand_lag());
    end
  endtask

  // wait until every queued transaction is taken and every result is back
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_reqs.size() != 0 || in_valid_i || expected_verdicts.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      ssll_pkg::CFG_W0:     sh_w0 = val;
      ssll_pkg::CFG_LAMBDA: sh_lambda = val;
      ssll_pkg::CFG_ALPHA:  sh_alpha = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the gamma entries that the tests can reach before any test reads them.
    for (int k = 0; k < GAMMA_FILL; k++) queue_load(k, rand_gamma());
    // Directed part with reset settings: first test, p extremes, lag extremes.
    queue_test('0, 0);
    queue_test(FRAC_MAX, 1023);
    queue_test('0, 0);
    queue_test('0, 1);
    queue_test(32'h0000_0001, 0);
    queue_test(ssll_pkg::LAMBDA_RST, 0);
    queue_test('0, 1023);           // lag reaches past the start of history
    queue_test(32'h0010_0000, 2);
    queue_load(0, FRAC_MAX);
    queue_load(MAX_TESTS - 1, '0);
    queue_load(1, 32'h0100_0000);
    queue_test('0, 0);
    queue_test(FRAC_MAX, 0);
    queue_test('0, 3);
    queue_test($urandom(), 0);
    queue_test('0, 0);
    drain();

    write_reg(ssll_pkg::CFG_W0, $urandom());
    write_reg(ssll_pkg::CFG_LAMBDA, $urandom());
    write_reg(ssll_pkg::CFG_ALPHA, $urandom());
    end_writes();
    queue_random(45);
    drain();

    // extremes: full wealth, zero cap, full alpha; the spare index is a no-op
    write_reg(ssll_pkg::CFG_W0, FRAC_MAX);
    write_reg(ssll_pkg::CFG_LAMBDA, '0);
    write_reg(ssll_pkg::CFG_ALPHA, FRAC_MAX);
    write_reg(CFG_SPARE, $urandom());
    end_writes();
    queue_random(45);
    drain();

    write_reg(ssll_pkg::CFG_W0, '0);
    write_reg(ssll_pkg::CFG_LAMBDA, FRAC_MAX);
    write_reg(ssll_pkg::CFG_ALPHA, '0);
    end_writes();
    queue_random(45);
    drain();

    // Back to the reset values for a short tail with long lags.
    write_reg(ssll_pkg::CFG_W0, ssll_pkg::W0_RST);
    write_reg(ssll_pkg::CFG_LAMBDA, ssll_pkg::LAMBDA_RST);
    write_reg(ssll_pkg::CFG_ALPHA, ssll_pkg::ALPHA_RST);
    end_writes();
    queue_test('0, 0);
    queue_load(5, $urandom());
    queue_test(FRAC_MAX, 1023);
    queue_test($urandom(), $urandom_range(0, 1023));
    drain();

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** saffron_star_lagged_levels: PASSED **");
    end else begin
      $display("** saffron_star_lagged_levels: FAILED **");
    end
    $finish;
  end

endmodule
